[sv/etf_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the escape-time fractal pixel block.
// Used by etf_ctrl, etf_datapath and the top level; no dependencies.
package etf_pkg;

  localparam int COORD_BITS_DEF = 32;
  localparam int FRAC_BITS_DEF  = 28;
  localparam int COUNT_BITS_DEF = 16;

  // configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_ITER  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_VARIANT   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_JULIA_RE  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_JULIA_IM  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RED_OFS   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_GREEN_OFS = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_BLUE_OFS  = 3'd6;

  typedef enum logic [1:0] {
    VAR_MANDELBROT,
    VAR_BURNING_SHIP,
    VAR_TRICORN,
    VAR_JULIA
  } variant_t;

  // colour ramp: t in Q0.TFRAC
  localparam int TFRAC      = 16;
  localparam int GAIN_W     = 12;
  localparam int RED_GAIN   = 1800;
  localparam int GREEN_GAIN = 3300;
  localparam int BLUE_GAIN  = 3995;

  // sequencing
  localparam int MUL_STEPS  = 4;      // half-width partial products per iteration
  localparam int DIV_STEPS  = TFRAC;  // one quotient bit per cycle
  localparam int STEP_CNT_W = 5;

  typedef struct packed {
    logic       load_item;
    logic       clr_acc;
    logic       issue;
    logic [1:0] step;
    logic       accum;
    logic       eval;
    logic       update;
    logic       div_init;
    logic       div_step;
    logic       col1;
    logic       col2;
    logic       col3;
    logic       load_out;
  } etf_cmd_t;

  typedef struct packed {
    logic at_limit;
    logic escaped;
  } etf_stat_t;

endpackage

[sv/etf_ctrl.sv]
`timescale 1ns / 1ps
// Controller of the escape-time fractal pixel block: sequences iterations,
// partial products, the t divider and the colour stages. Uses etf_pkg.
module etf_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  input  etf_pkg::etf_stat_t  stat,
  output etf_pkg::etf_cmd_t   cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_TEST,
    S_MUL,
    S_EVAL,
    S_UPD,
    S_DIV,
    S_COL1,
    S_COL2,
    S_COL3,
    S_DONE
  } state_t;

  state_t                             state_r, state_nxt;
  logic [etf_pkg::STEP_CNT_W-1:0]     cnt_r, cnt_nxt;
  logic                               out_valid_r, out_valid_nxt;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r;
    cmd           = '0;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_item = 1'b1;
          state_nxt     = S_TEST;
        end
      end
      S_TEST: begin
        cnt_nxt = '0;
        if (stat.at_limit) begin
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        // issue product k while the one before is summed in
        cmd.clr_acc = (cnt_r == '0);
        cmd.issue   = (cnt_r < etf_pkg::STEP_CNT_W'(etf_pkg::MUL_STEPS));
        cmd.step    = cnt_r[1:0];
        cmd.accum   = (cnt_r != '0);
        if (cnt_r == etf_pkg::STEP_CNT_W'(etf_pkg::MUL_STEPS)) begin
          cnt_nxt   = '0;
          state_nxt = S_EVAL;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_EVAL: begin
        cmd.eval  = 1'b1;
        state_nxt = S_UPD;
      end
      S_UPD: begin
        if (stat.escaped) begin
          cmd.div_init = 1'b1;
          cnt_nxt      = '0;
          state_nxt    = S_DIV;
        end else begin
          cmd.update = 1'b1;
          state_nxt  = S_TEST;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (cnt_r == etf_pkg::STEP_CNT_W'(etf_pkg::DIV_STEPS - 1)) begin
          cnt_nxt   = '0;
          state_nxt = S_COL1;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_COL1: begin
        cmd.col1  = 1'b1;
        state_nxt = S_COL2;
      end
      S_COL2: begin
        cmd.col2  = 1'b1;
        state_nxt = S_COL3;
      end
      S_COL3: begin
        cmd.col3  = 1'b1;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        // hold until the output register is free
        if (!out_valid_r || !out_stall) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

[sv/etf_datapath.sv]
`timescale 1ns / 1ps
// Datapath of the escape-time fractal pixel block: configuration registers,
// z iteration with half-width multipliers, t divider, colour ramp. Uses etf_pkg.
module etf_datapath #(
  parameter int COORD_BITS = etf_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS  = etf_pkg::FRAC_BITS_DEF,
  parameter int COUNT_BITS = etf_pkg::COUNT_BITS_DEF,
  parameter int CFG_W      = COORD_BITS
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [etf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_W-1:0]               cfg_data,
  input  logic signed [COORD_BITS-1:0]   in_c_re,
  input  logic signed [COORD_BITS-1:0]   in_c_im,
  input  etf_pkg::etf_cmd_t              cmd,
  output etf_pkg::etf_stat_t             stat,
  output logic [COUNT_BITS-1:0]          out_iteration_count,
  output logic                           out_inside_res,
  output logic [23:0]                    out_color
);

  localparam int CW   = COORD_BITS;
  localparam int H    = (CW + 1) / 2;
  localparam int HW   = 2 * H;
  localparam int PW   = 2 * CW;
  localparam logic [PW:0] THR = {{PW{1'b0}}, 1'b1} << (2 * FRAC_BITS + 2);
  localparam logic [CW:0] CHALF = {1'b1, {(CW - 1){1'b0}}} >> 0;

  localparam int TF   = etf_pkg::TFRAC;
  localparam int UW   = TF + 1;
  localparam int UUW  = 2 * UW;
  localparam int UTW  = UW + TF;
  localparam int UUTW = UUW + TF;
  localparam int UTTW = UTW + TF;
  localparam int GPW  = UUTW + etf_pkg::GAIN_W;
  localparam int CHW  = 12;

  // configuration
  logic [COUNT_BITS-1:0]   max_iter_r;
  etf_pkg::variant_t       variant_r;
  logic [CW-1:0]           julia_re_r, julia_im_r;
  logic [7:0]              red_ofs_r, green_ofs_r, blue_ofs_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_iter_r  <= COUNT_BITS'(100);
      variant_r   <= etf_pkg::VAR_MANDELBROT;
      julia_re_r  <= '0;
      julia_im_r  <= '0;
      red_ofs_r   <= '0;
      green_ofs_r <= '0;
      blue_ofs_r  <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        etf_pkg::REG_MAX_ITER:  max_iter_r  <= cfg_data[COUNT_BITS-1:0];
        etf_pkg::REG_VARIANT:   variant_r   <= etf_pkg::variant_t'(cfg_data[1:0]);
        etf_pkg::REG_JULIA_RE:  julia_re_r  <= cfg_data[CW-1:0];
        etf_pkg::REG_JULIA_IM:  julia_im_r  <= cfg_data[CW-1:0];
        etf_pkg::REG_RED_OFS:   red_ofs_r   <= cfg_data[7:0];
        etf_pkg::REG_GREEN_OFS: green_ofs_r <= cfg_data[7:0];
        etf_pkg::REG_BLUE_OFS:  blue_ofs_r  <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // two's complement to sign and magnitude
  function automatic logic [CW:0] from_bits(input logic [CW-1:0] v);
    logic          neg;
    logic [CW-1:0] mag;
    neg = v[CW-1];
    mag = neg ? (~v + 1'b1) : v;
    return {neg, mag};
  endfunction

  // signed add of sign/magnitude values, saturated to the coordinate range
  function automatic logic [CW:0] add_sat(input logic xn, input logic [CW-1:0] xm,
                                          input logic yn, input logic [CW-1:0] ym);
    logic          rn;
    logic [CW:0]   rm;
    logic [CW:0]   bound;
    if (xn == yn) begin
      rn = xn;
      rm = {1'b0, xm} + {1'b0, ym};
    end else if (xm >= ym) begin
      rn = xn;
      rm = {1'b0, xm - ym};
    end else begin
      rn = yn;
      rm = {1'b0, ym - xm};
    end
    bound = rn ? CHALF : (CHALF - 1'b1);
    if (rm > bound) begin
      rm = bound;
    end
    if (rm == '0) begin
      rn = 1'b0;
    end
    return {rn, rm[CW-1:0]};
  endfunction

  // item state
  logic                    zr_neg_r, zi_neg_r, ar_neg_r, ai_neg_r;
  logic [CW-1:0]           zr_mag_r, zi_mag_r, ar_mag_r, ai_mag_r;
  logic [COUNT_BITS-1:0]   iter_r;

  logic [CW:0]             cr_sm, ci_sm, jr_sm, ji_sm;
  assign cr_sm = from_bits(in_c_re);
  assign ci_sm = from_bits(in_c_im);
  assign jr_sm = from_bits(julia_re_r);
  assign ji_sm = from_bits(julia_im_r);

  // partial-product multiply: zr*zr, zi*zi, zr*zi one half pair per step
  logic [HW-1:0]  zr_ext, zi_ext;
  logic [H-1:0]   zr_a, zr_b, zi_a, zi_b;
  logic [HW-1:0]  p_sr_r, p_si_r, p_x_r;
  logic [1:0]     pstep_r;
  logic [PW-1:0]  sr_r, si_r, x_r;
  logic [PW-1:0]  add_sr, add_si, add_x;

  assign zr_ext = HW'(zr_mag_r);
  assign zi_ext = HW'(zi_mag_r);
  assign zr_a   = cmd.step[1] ? zr_ext[HW-1:H] : zr_ext[H-1:0];
  assign zr_b   = cmd.step[0] ? zr_ext[HW-1:H] : zr_ext[H-1:0];
  assign zi_a   = cmd.step[1] ? zi_ext[HW-1:H] : zi_ext[H-1:0];
  assign zi_b   = cmd.step[0] ? zi_ext[HW-1:H] : zi_ext[H-1:0];

  always_comb begin
    case (pstep_r)
      2'd0: begin
        add_sr = PW'(p_sr_r);
        add_si = PW'(p_si_r);
        add_x  = PW'(p_x_r);
      end
      2'd3: begin
        add_sr = PW'(p_sr_r) << (2 * H);
        add_si = PW'(p_si_r) << (2 * H);
        add_x  = PW'(p_x_r) << (2 * H);
      end
      default: begin
        add_sr = PW'(p_sr_r) << H;
        add_si = PW'(p_si_r) << H;
        add_x  = PW'(p_x_r) << H;
      end
    endcase
  end

  // escape test and the new parts before the constant is added
  logic [PW:0]      mag_sum;
  logic             sr_ge;
  logic [PW-1:0]    sq_diff, diff_sh, x_sh;
  logic [CW-1:0]    re_clamp, im_clamp;
  logic             escaped_r;
  logic             re_neg_r, im_neg_r;
  logic [CW-1:0]    re_mag_r, im_mag_r;
  logic [CW:0]      zr_new, zi_new;

  assign mag_sum  = {1'b0, sr_r} + {1'b0, si_r};
  assign sr_ge    = (sr_r >= si_r);
  assign sq_diff  = sr_ge ? (sr_r - si_r) : (si_r - sr_r);
  assign diff_sh  = sq_diff >> FRAC_BITS;
  assign x_sh     = x_r >> (FRAC_BITS - 1);
  assign re_clamp = (|diff_sh[PW-1:CW]) ? '1 : diff_sh[CW-1:0];
  assign im_clamp = (|x_sh[PW-1:CW]) ? '1 : x_sh[CW-1:0];

  assign zr_new = add_sat(re_neg_r, re_mag_r, ar_neg_r, ar_mag_r);
  assign zi_new = add_sat(im_neg_r, im_mag_r, ai_neg_r, ai_mag_r);

  assign stat.at_limit = (iter_r == max_iter_r);
  assign stat.escaped  = escaped_r;

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      iter_r <= '0;
      if (variant_r == etf_pkg::VAR_JULIA) begin
        {ar_neg_r, ar_mag_r} <= jr_sm;
        {ai_neg_r, ai_mag_r} <= ji_sm;
      end else begin
        {ar_neg_r, ar_mag_r} <= cr_sm;
        {ai_neg_r, ai_mag_r} <= ci_sm;
      end
      if (variant_r == etf_pkg::VAR_BURNING_SHIP) begin
        {zr_neg_r, zr_mag_r} <= '0;
        {zi_neg_r, zi_mag_r} <= '0;
      end else begin
        {zr_neg_r, zr_mag_r} <= cr_sm;
        {zi_neg_r, zi_mag_r} <= ci_sm;
      end
    end
    if (cmd.issue) begin
      p_sr_r  <= HW'(zr_a) * HW'(zr_b);
      p_si_r  <= HW'(zi_a) * HW'(zi_b);
      p_x_r   <= HW'(zr_a) * HW'(zi_b);
      pstep_r <= cmd.step;
    end
    if (cmd.clr_acc) begin
      sr_r <= '0;
      si_r <= '0;
      x_r  <= '0;
    end else if (cmd.accum) begin
      sr_r <= sr_r + add_sr;
      si_r <= si_r + add_si;
      x_r  <= x_r + add_x;
    end
    if (cmd.eval) begin
      escaped_r <= (mag_sum >= THR);
      re_neg_r  <= !sr_ge;
      re_mag_r  <= re_clamp;
      im_neg_r  <= zr_neg_r ^ zi_neg_r ^ (variant_r == etf_pkg::VAR_TRICORN);
      im_mag_r  <= im_clamp;
    end
    if (cmd.update) begin
      iter_r   <= iter_r + 1'b1;
      zr_mag_r <= zr_new[CW-1:0];
      zi_mag_r <= zi_new[CW-1:0];
      // burning ship folds both parts to the positive side
      zr_neg_r <= zr_new[CW] && (variant_r != etf_pkg::VAR_BURNING_SHIP);
      zi_neg_r <= zi_new[CW] && (variant_r != etf_pkg::VAR_BURNING_SHIP);
    end
  end

  // t = iter / limit in Q0.TFRAC, restoring division, one bit a cycle
  logic [COUNT_BITS-1:0]  rem_r;
  logic [TF-1:0]          quo_r;
  logic [COUNT_BITS:0]    rem_sh, rem_sub;

  assign rem_sh  = {rem_r, 1'b0};
  assign rem_sub = rem_sh - {1'b0, max_iter_r};

  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      rem_r <= iter_r;
      quo_r <= '0;
    end else if (cmd.div_step) begin
      if (rem_sh >= {1'b0, max_iter_r}) begin
        rem_r <= rem_sub[COUNT_BITS-1:0];
        quo_r <= {quo_r[TF-2:0], 1'b1};
      end else begin
        rem_r <= rem_sh[COUNT_BITS-1:0];
        quo_r <= {quo_r[TF-2:0], 1'b0};
      end
    end
  end

  // colour polynomials, one level of multiplies per stage (col1, col2, col3)
  logic [UW-1:0]    u_val;
  logic [TF-1:0]    t_hold_r;
  logic [UUW-1:0]   uu_r;
  logic [UTW-1:0]   ut_r;
  logic [UUTW-1:0]  uut_r;
  logic [UTTW-1:0]  utt_r;
  logic [GPW-1:0]   rp_r, gp_r, bp_r;

  assign u_val = {1'b1, {TF{1'b0}}} - {1'b0, quo_r};

  always_ff @(posedge clk) begin
    if (cmd.col1) begin
      uu_r     <= UUW'(u_val) * UUW'(u_val);
      ut_r     <= UTW'(u_val) * UTW'(quo_r);
      t_hold_r <= quo_r;
    end
    if (cmd.col2) begin
      uut_r <= UUTW'(uu_r) * UUTW'(t_hold_r);
      utt_r <= UTTW'(ut_r) * UTTW'(t_hold_r);
    end
    if (cmd.col3) begin
      rp_r <= GPW'(uut_r) * GPW'(etf_pkg::RED_GAIN);
      gp_r <= GPW'(utt_r) * GPW'(etf_pkg::GREEN_GAIN);
      bp_r <= GPW'(utt_r) * GPW'(etf_pkg::BLUE_GAIN);
    end
  end

  logic [CHW-1:0]  red_base, green_base, blue_base;
  logic [CHW:0]    red_sum, green_sum, blue_sum;
  logic [7:0]      red_ch, green_ch, blue_ch;

  assign red_base   = CHW'(rp_r >> (3 * TF));
  assign green_base = CHW'(gp_r >> (3 * TF));
  assign blue_base  = CHW'(bp_r >> (3 * TF + 1));
  assign red_sum    = {1'b0, red_base} + (CHW + 1)'(red_ofs_r);
  assign green_sum  = {1'b0, green_base} + (CHW + 1)'(green_ofs_r);
  assign blue_sum   = {1'b0, blue_base} + (CHW + 1)'(blue_ofs_r);
  assign red_ch     = (red_sum > (CHW + 1)'(255)) ? 8'hFF : red_sum[7:0];
  assign green_ch   = (green_sum > (CHW + 1)'(255)) ? 8'hFF : green_sum[7:0];
  assign blue_ch    = (blue_sum > (CHW + 1)'(255)) ? 8'hFF : blue_sum[7:0];

  // output register; at the limit the pixel is black
  logic [COUNT_BITS-1:0]  out_count_r;
  logic                   out_inside_r;
  logic [23:0]            out_color_r;

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_count_r  <= iter_r;
      out_inside_r <= stat.at_limit;
      out_color_r  <= stat.at_limit ? 24'd0 : {red_ch, green_ch, blue_ch};
    end
  end

  assign out_iteration_count = out_count_r;
  assign out_inside_res      = out_inside_r;
  assign out_color           = out_color_r;

endmodule

[sv/escape_time_fractal_pixel.sv]
`timescale 1ns / 1ps
// Top level of the escape-time fractal pixel block: controller and datapath.
// Depends on etf_pkg, etf_ctrl and etf_datapath.
//
//   channel  direction  handshake              payload
//   in       input      in_valid / in_stall    in_c_re, in_c_im (signed fixed point)
//   out      output     out_valid / out_stall  out_iteration_count, out_inside_res,
//                                              out_color
//   cfg      input      cfg_we                 cfg_index, cfg_data
//
// Each iteration runs test, four half-width partial-product steps plus one
// sum-in step, evaluate and update on the shared multipliers; an escaping
// point then adds the t divider and 3 colour stages.
// Reset (rst_n low, synchronous) restores the register defaults and empties
// the output register. A stalled result sits in the output register while the
// next point is taken in; the block holds its last cycle until it drains.
module escape_time_fractal_pixel #(
  parameter int COORD_BITS = etf_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS  = etf_pkg::FRAC_BITS_DEF,
  parameter int COUNT_BITS = etf_pkg::COUNT_BITS_DEF,
  localparam int CFG_W     = (COORD_BITS > COUNT_BITS) ? COORD_BITS : COUNT_BITS
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic signed [COORD_BITS-1:0]   in_c_re,
  input  logic signed [COORD_BITS-1:0]   in_c_im,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [COUNT_BITS-1:0]          out_iteration_count,
  output logic                           out_inside_res,
  output logic [23:0]                    out_color,
  input  logic                           cfg_we,
  input  logic [etf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_W-1:0]               cfg_data
);

  etf_pkg::etf_cmd_t   cmd;
  etf_pkg::etf_stat_t  stat;

  etf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  etf_datapath #(
    .COORD_BITS (COORD_BITS),
    .FRAC_BITS  (FRAC_BITS),
    .COUNT_BITS (COUNT_BITS),
    .CFG_W      (CFG_W)
  ) u_datapath (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .in_c_re             (in_c_re),
    .in_c_im             (in_c_im),
    .cmd                 (cmd),
    .stat                (stat),
    .out_iteration_count (out_iteration_count),
    .out_inside_res      (out_inside_res),
    .out_color           (out_color)
  );

endmodule
